/* sv/plane_outlier_closest_point_defines.svh */
// Assertion macros for the plane outlier closest point block
`ifndef PLANE_OUTLIER_CLOSEST_POINT_DEFINES_SVH
`define PLANE_OUTLIER_CLOSEST_POINT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk_i, off during reset
`define POC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, clocked on clk_i, off during reset
`define POC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define POC_ASSERT_IMPL(lbl, ante, cons, msg)
`define POC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/poc_pkg.sv */
// Types and constants shared by the plane outlier closest point block
`timescale 1ns / 1ps
`default_nettype none
package poc_pkg;

  localparam int COORD_W    = 16;
  localparam int NORM_W     = 16;
  localparam int NORM_FRAC  = 14;
  localparam int OFFS_W     = 18;
  localparam int THR_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int PROD_W    = COORD_W + NORM_W;
  localparam int OFFS_SH_W = OFFS_W + NORM_FRAC;
  localparam int DIST_W    = ((PROD_W > OFFS_SH_W) ? PROD_W : OFFS_SH_W) + 2;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  localparam logic signed [NORM_W-1:0] NORMAL_X_RST = '0;
  localparam logic signed [NORM_W-1:0] NORMAL_Y_RST = '0;
  localparam logic signed [NORM_W-1:0] NORMAL_Z_RST = NORM_W'(16384);
  localparam logic signed [OFFS_W-1:0] OFFSET_RST   = '0;
  localparam logic [THR_W-1:0]         THR_RST      = THR_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NORMAL_X = 3'd0,
    REG_NORMAL_Y = 3'd1,
    REG_NORMAL_Z = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_DIST_THR = 3'd4
  } poc_reg_e;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic signed [OFFS_W-1:0] plane_offset;
    logic [THR_W-1:0]         dist_thr;
  } poc_cfg_t;

  // candidate point leaving the distance pipeline
  typedef struct packed {
    logic signed [DIST_W-1:0]  sdist;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      test;
    logic                      last;
  } poc_cand_t;

endpackage
`default_nettype wire

/* sv/poc_in_if.sv */
// Point request channel: valid/ready plus one depth point
`timescale 1ns / 1ps
`default_nettype none
interface poc_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [poc_pkg::COORD_W-1:0] point_x;
  logic signed [poc_pkg::COORD_W-1:0] point_y;
  logic signed [poc_pkg::COORD_W-1:0] point_z;
  logic                               point_valid;
  logic                               on_plane;
  logic                               last_point;

  modport source (
    output valid, point_x, point_y, point_z, point_valid, on_plane, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, point_valid, on_plane, last_point,
    output ready
  );
endinterface
`default_nettype wire

/* sv/poc_out_if.sv */
// Obstacle result channel: valid/ready plus the frame's closest outlier
`timescale 1ns / 1ps
`default_nettype none
interface poc_out_if;
  logic                               valid;
  logic                               ready;
  logic                               obstacle_hit;
  logic signed [poc_pkg::COORD_W-1:0] obstacle_x;
  logic signed [poc_pkg::COORD_W-1:0] obstacle_y;
  logic signed [poc_pkg::COORD_W-1:0] obstacle_z;

  modport source (
    output valid, obstacle_hit, obstacle_x, obstacle_y, obstacle_z,
    input  ready
  );
  modport sink (
    input  valid, obstacle_hit, obstacle_x, obstacle_y, obstacle_z,
    output ready
  );
endinterface
`default_nettype wire

/* sv/poc_cfg_regs.sv */
// Configuration register file: plane normal, offset and distance threshold
`timescale 1ns / 1ps
`default_nettype none
module poc_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [poc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [poc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output poc_pkg::poc_cfg_t                     cfg_o
);

  poc_pkg::poc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (poc_pkg::poc_reg_e'(cfg_idx_i))
        poc_pkg::REG_NORMAL_X: cfg_d.normal_x     = cfg_data_i[poc_pkg::NORM_W-1:0];
        poc_pkg::REG_NORMAL_Y: cfg_d.normal_y     = cfg_data_i[poc_pkg::NORM_W-1:0];
        poc_pkg::REG_NORMAL_Z: cfg_d.normal_z     = cfg_data_i[poc_pkg::NORM_W-1:0];
        poc_pkg::REG_OFFSET:   cfg_d.plane_offset = cfg_data_i[poc_pkg::OFFS_W-1:0];
        poc_pkg::REG_DIST_THR: cfg_d.dist_thr     = cfg_data_i[poc_pkg::THR_W-1:0];
        default: ;  // unused indices are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_x     <= poc_pkg::NORMAL_X_RST;
      cfg_q.normal_y     <= poc_pkg::NORMAL_Y_RST;
      cfg_q.normal_z     <= poc_pkg::NORMAL_Z_RST;
      cfg_q.plane_offset <= poc_pkg::OFFSET_RST;
      cfg_q.dist_thr     <= poc_pkg::THR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

/* sv/poc_dist_pipe.sv */
// Three-stage signed plane distance pipeline: input reg, products, sum
`timescale 1ns / 1ps
`default_nettype none
module poc_dist_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  poc_in_if.sink                  pt_i,
  input  wire poc_pkg::poc_cfg_t  cfg_i,
  output logic                    cand_valid_o,
  input  wire logic               cand_ready_i,
  output poc_pkg::poc_cand_t      cand_o
);

  localparam int CW = poc_pkg::COORD_W;
  localparam int PW = poc_pkg::PROD_W;
  localparam int OW = poc_pkg::OFFS_SH_W;
  localparam int DW = poc_pkg::DIST_W;

  logic s1_ready, s2_ready, s3_ready;
  logic s1_v_q, s1_v_d, s2_v_q, s2_v_d, s3_v_q, s3_v_d;

  // stage 1: registered point
  logic signed [CW-1:0] s1_x_q, s1_y_q, s1_z_q;
  logic                 s1_test_q, s1_last_q;

  // stage 2: products and scaled offset
  logic signed [PW-1:0] s2_px_q, s2_py_q, s2_pz_q;
  logic signed [PW-1:0] s2_px_d, s2_py_d, s2_pz_d;
  logic signed [OW-1:0] s2_off_q, s2_off_d;
  logic signed [CW-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic                 s2_test_q, s2_last_q;

  // stage 3: full signed distance
  poc_pkg::poc_cand_t s3_q, s3_d;

  assign s3_ready = !s3_v_q || cand_ready_i;
  assign s2_ready = !s2_v_q || s3_ready;
  assign s1_ready = !s1_v_q || s2_ready;
  assign pt_i.ready = s1_ready;

  assign s1_v_d = s1_ready ? pt_i.valid : s1_v_q;
  assign s2_v_d = s2_ready ? s1_v_q : s2_v_q;
  assign s3_v_d = s3_ready ? s2_v_q : s3_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
      s3_v_q <= s3_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && pt_i.valid) begin
      s1_x_q    <= pt_i.point_x;
      s1_y_q    <= pt_i.point_y;
      s1_z_q    <= pt_i.point_z;
      s1_test_q <= pt_i.point_valid && !pt_i.on_plane;
      s1_last_q <= pt_i.last_point;
    end
  end

  always_comb begin
    s2_px_d  = s1_x_q * cfg_i.normal_x;
    s2_py_d  = s1_y_q * cfg_i.normal_y;
    s2_pz_d  = s1_z_q * cfg_i.normal_z;
    s2_off_d = $signed({cfg_i.plane_offset, {poc_pkg::NORM_FRAC{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_v_q) begin
      s2_px_q   <= s2_px_d;
      s2_py_q   <= s2_py_d;
      s2_pz_q   <= s2_pz_d;
      s2_off_q  <= s2_off_d;
      s2_x_q    <= s1_x_q;
      s2_y_q    <= s1_y_q;
      s2_z_q    <= s1_z_q;
      s2_test_q <= s1_test_q;
      s2_last_q <= s1_last_q;
    end
  end

  always_comb begin
    s3_d.sdist = DW'(s2_px_q) + DW'(s2_py_q) + DW'(s2_pz_q) + DW'(s2_off_q);
    s3_d.x     = s2_x_q;
    s3_d.y     = s2_y_q;
    s3_d.z     = s2_z_q;
    s3_d.test  = s2_test_q;
    s3_d.last  = s2_last_q;
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_v_q) begin
      s3_q <= s3_d;
    end
  end

  assign cand_valid_o = s3_v_q;
  assign cand_o       = s3_q;

endmodule
`default_nettype wire

/* sv/poc_best_track.sv */
// Threshold test, running closest-point tracker and result register
`timescale 1ns / 1ps
`default_nettype none
module poc_best_track (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [poc_pkg::THR_W-1:0]    dist_thr_i,
  input  wire logic                         cand_valid_i,
  output logic                              cand_ready_o,
  input  wire poc_pkg::poc_cand_t           cand_i,
  poc_out_if.source                         obs_o
);

  localparam int CW = poc_pkg::COORD_W;
  localparam int DW = poc_pkg::DIST_W;

  logic signed [DW-1:0] thr_pos, thr_neg;
  logic                 outlier, take, go, out_free;

  logic signed [CW-1:0] best_x_q, best_y_q, best_z_q;
  logic signed [CW-1:0] best_x_d, best_y_d, best_z_d;
  logic                 best_ok_q, best_ok_d;
  logic signed [CW-1:0] nb_x, nb_y, nb_z;
  logic                 nb_ok;

  logic                 out_v_q, out_v_d;
  logic                 out_found_q;
  logic signed [CW-1:0] out_x_q, out_y_q, out_z_q;

  // |dist| > thr * 2^F, done as two signed compares
  assign thr_pos = $signed(DW'({dist_thr_i, {poc_pkg::NORM_FRAC{1'b0}}}));
  assign thr_neg = -thr_pos;
  assign outlier = cand_i.test && ((cand_i.sdist > thr_pos) || (cand_i.sdist < thr_neg));
  assign take    = outlier && (!best_ok_q || (cand_i.z < best_z_q));

  assign nb_x  = take ? cand_i.x : best_x_q;
  assign nb_y  = take ? cand_i.y : best_y_q;
  assign nb_z  = take ? cand_i.z : best_z_q;
  assign nb_ok = take || best_ok_q;

  // a last item needs the result slot; others pass freely
  assign out_free     = !out_v_q || obs_o.ready;
  assign cand_ready_o = !cand_i.last || out_free;
  assign go           = cand_valid_i && cand_ready_o;

  always_comb begin
    best_x_d  = best_x_q;
    best_y_d  = best_y_q;
    best_z_d  = best_z_q;
    best_ok_d = best_ok_q;
    if (go) begin
      if (cand_i.last) begin
        best_x_d  = '0;
        best_y_d  = '0;
        best_z_d  = poc_pkg::COORD_MAX;
        best_ok_d = 1'b0;
      end else begin
        best_x_d  = nb_x;
        best_y_d  = nb_y;
        best_z_d  = nb_z;
        best_ok_d = nb_ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_x_q  <= '0;
      best_y_q  <= '0;
      best_z_q  <= poc_pkg::COORD_MAX;
      best_ok_q <= 1'b0;
    end else begin
      best_x_q  <= best_x_d;
      best_y_q  <= best_y_d;
      best_z_q  <= best_z_d;
      best_ok_q <= best_ok_d;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (go && cand_i.last) begin
      out_v_d = 1'b1;
    end else if (obs_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && cand_i.last) begin
      out_found_q <= nb_ok;
      out_x_q     <= nb_x;
      out_y_q     <= nb_y;
      out_z_q     <= nb_z;
    end
  end

  assign obs_o.valid        = out_v_q;
  assign obs_o.obstacle_hit = out_found_q;
  assign obs_o.obstacle_x   = out_x_q;
  assign obs_o.obstacle_y   = out_y_q;
  assign obs_o.obstacle_z   = out_z_q;

endmodule
`default_nettype wire

/* sv/plane_outlier_closest_point.sv */
// Plane outlier closest point finder: top level
//
// Usage: a frame of depth points streams in on pt_i, one point per request.
// Points with point_valid set and on_plane clear are tested against the
// plane n.p/2^14 + offset; an outlier beyond distance_threshold with the
// smallest z (first one wins on ties) is kept. The request marked
// last_point closes the frame and yields exactly one result on obs_o:
// obstacle_hit plus the kept point (0, 0, 32767 when nothing was found).
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Throughput: one point per cycle, sustained while no closing point waits
// on a pending result. The result passes the input register, product
// register, distance register, then the result register after the last
// point is accepted. The running-minimum update at the end of the pipe sets the rate.
// Reset: config returns to n = (0, 0, 1.0), offset 0, threshold 100; the
// pipeline empties and the kept point clears. No clearing pass is needed.
// Stall: a waiting result only blocks a following last point; other points
// keep flowing, and pt_i.ready drops only once the pipe fills behind it.
`timescale 1ns / 1ps
`default_nettype none
`include "plane_outlier_closest_point_defines.svh"
module plane_outlier_closest_point (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  poc_in_if.sink                              pt_i,
  poc_out_if.source                           obs_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [poc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [poc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  poc_pkg::poc_cfg_t  cfg;
  poc_pkg::poc_cand_t cand;
  logic               cand_valid;
  logic               cand_ready;

  poc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // distance pipe: point in, signed distance scaled by 2^14 out
  poc_dist_pipe u_pipe (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pt_i         (pt_i),
    .cfg_i        (cfg),
    .cand_valid_o (cand_valid),
    .cand_ready_i (cand_ready),
    .cand_o       (cand)
  );

  // threshold test, running minimum, result register
  poc_best_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dist_thr_i   (cfg.dist_thr),
    .cand_valid_i (cand_valid),
    .cand_ready_o (cand_ready),
    .cand_i       (cand),
    .obs_o        (obs_o)
  );

  // input only backs up when the tracker is holding an item
  `POC_ASSERT_IMPL(a_stall_src, !pt_i.ready, cand_valid, "input stalled with empty tracker")
  // a closing point must wait while the result slot is occupied
  `POC_ASSERT_IMPL(a_last_hold, obs_o.valid && !obs_o.ready && cand_valid && cand.last,
    !cand_ready, "last point taken over a pending result")
  // a closing point always produces a result next cycle
  `POC_ASSERT_NEXT(a_last_out, cand_valid && cand_ready && cand.last, obs_o.valid,
    "frame closed without a result")
  // no obstacle means the cleared sentinel point
  `POC_ASSERT_IMPL(a_none_zero, obs_o.valid && !obs_o.obstacle_hit,
    obs_o.obstacle_x == '0 && obs_o.obstacle_y == '0 && obs_o.obstacle_z == poc_pkg::COORD_MAX,
    "empty result with non-sentinel point")

endmodule
`default_nettype wire

/* test/tb_plane_outlier_closest_point.sv */
// Self-checking testbench for the plane outlier closest point finder
`timescale 1ns / 1ps
module tb_plane_outlier_closest_point;

  // Run shape: a directed warm-up at reset config, then phases of random
  // frames. Every phase reprograms the plane, and the first two phases use
  // the register extremes.
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 124;
  localparam int HOLD_PHASE      = 3;      // phase with the long result hold-off
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 10;     // settle margin after the last result
  localparam int CYCLE_LIMIT     = 200000;
  localparam int MAX_REPORTS     = 40;

  localparam int CW     = poc_pkg::COORD_W;
  localparam int CFG_DW = poc_pkg::CFG_DATA_W;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 valid;
    logic                 on_plane;
    logic                 last;
  } depth_point_t;

  typedef struct {
    logic                 found;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } obstacle_t;

  // Tracks the plane config and the running closest outlier of the current
  // frame; queues one expected obstacle per closed frame.
  class obstacle_scoreboard;
    logic signed [poc_pkg::NORM_W-1:0] nrm_x, nrm_y, nrm_z;
    logic signed [poc_pkg::OFFS_W-1:0] offset;
    logic [poc_pkg::THR_W-1:0]         thr;
    logic signed [CW-1:0]              keep_x, keep_y, keep_z;
    bit                                keep_ok;
    obstacle_t                         obstacle_q[$];
    int                                errors;

    function new();
      nrm_x   = poc_pkg::NORMAL_X_RST;
      nrm_y   = poc_pkg::NORMAL_Y_RST;
      nrm_z   = poc_pkg::NORMAL_Z_RST;
      offset  = poc_pkg::OFFSET_RST;
      thr     = poc_pkg::THR_RST;
      errors  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      keep_x  = '0;
      keep_y  = '0;
      keep_z  = poc_pkg::COORD_MAX;
      keep_ok = 1'b0;
    endfunction

    function void write_reg(poc_pkg::poc_reg_e idx, logic [CFG_DW-1:0] data);
      case (idx)
        poc_pkg::REG_NORMAL_X: nrm_x = data[poc_pkg::NORM_W-1:0];
        poc_pkg::REG_NORMAL_Y: nrm_y = data[poc_pkg::NORM_W-1:0];
        poc_pkg::REG_NORMAL_Z: nrm_z = data[poc_pkg::NORM_W-1:0];
        poc_pkg::REG_OFFSET:   offset = data[poc_pkg::OFFS_W-1:0];
        poc_pkg::REG_DIST_THR: thr = data[poc_pkg::THR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_point(depth_point_t p);
      longint    acc;
      longint    mag;
      obstacle_t res;
      if (p.valid && !p.on_plane) begin
        // exact compare at 2^NORM_FRAC scale, no rounding
        acc = longint'(nrm_x) * longint'(p.x) + longint'(nrm_y) * longint'(p.y)
            + longint'(nrm_z) * longint'(p.z)
            + longint'(offset) * (longint'(1) << poc_pkg::NORM_FRAC);
        mag = (acc < 0) ? -acc : acc;
        if (mag > longint'(thr) * (longint'(1) << poc_pkg::NORM_FRAC)) begin
          if (!keep_ok || p.z < keep_z) begin
            keep_x  = p.x;
            keep_y  = p.y;
            keep_z  = p.z;
            keep_ok = 1'b1;
          end
        end
      end
      if (p.last) begin
        res.found = keep_ok;
        res.x     = keep_x;
        res.y     = keep_y;
        res.z     = keep_z;
        obstacle_q.insert(obstacle_q.size(), res);
        clear_frame();
      end
    endfunction

    function void check_result(obstacle_t got);
      obstacle_t exp_res;
      if (obstacle_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: expected no result, got found=%0d x=%0d y=%0d z=%0d",
                   $time, got.found, got.x, got.y, got.z);
        return;
      end
      exp_res = obstacle_q.pop_front();
      if (got.found !== exp_res.found || got.x !== exp_res.x ||
          got.y !== exp_res.y || got.z !== exp_res.z) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: obstacle mismatch: expected found=%0d x=%0d y=%0d z=%0d,",
                    " got found=%0d x=%0d y=%0d z=%0d"},
                   $time, exp_res.found, exp_res.x, exp_res.y, exp_res.z,
                   got.found, got.x, got.y, got.z);
      end
    endfunction

    function int pending();
      return obstacle_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  poc_pkg::poc_reg_e  cfg_idx;
  logic [CFG_DW-1:0]  cfg_data;

  poc_in_if  pt_if ();
  poc_out_if obs_if ();

  plane_outlier_closest_point u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pt_i       (pt_if),
    .obs_o      (obs_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  obstacle_scoreboard sb = new();

  bit quiet;          // final part: no idling on either side
  bit hold_req;       // asks the result side for one long hold-off
  int items_sent;
  int cycle_count;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog: generous bound on the slowest legal run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random ready bursts, one long counted hold-off on request,
  // always ready in the quiet tail.
  initial begin
    obs_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (hold_req) begin
        obs_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        obs_if.ready = 1'b0;
        repeat ($urandom_range(1, 16)) @(negedge clk_i);
      end else begin
        obs_if.ready = 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(negedge clk_i);
      end
    end
  end

  // Result monitor, sampled at the rising edge.
  always @(posedge clk_i) begin
    obstacle_t got;
    if (rst_ni && obs_if.valid && obs_if.ready) begin
      got.found = obs_if.obstacle_hit;
      got.x     = obs_if.obstacle_x;
      got.y     = obs_if.obstacle_y;
      got.z     = obs_if.obstacle_z;
      sb.check_result(got);
    end
  end

  // Register write; only called while the block is drained.
  task automatic write_reg(poc_pkg::poc_reg_e idx, int value);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_DW'(value);
    @(negedge clk_i);
    cfg_we   = 1'b0;
    sb.write_reg(idx, CFG_DW'(value));
  endtask

  // Offers one point request; entered after a rising edge, returns at the
  // edge that accepts it. valid stays high into the next request unless a
  // gap is drawn.
  task automatic send_point(depth_point_t p);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      pt_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pt_if.valid       = 1'b1;
    pt_if.point_x     = p.x;
    pt_if.point_y     = p.y;
    pt_if.point_z     = p.z;
    pt_if.point_valid = p.valid;
    pt_if.on_plane    = p.on_plane;
    pt_if.last_point  = p.last;
    do @(posedge clk_i); while (!pt_if.ready);
    sb.note_point(p);
    items_sent++;
  endtask

  function automatic depth_point_t mk_point(int x, int y, int z, bit ok, bit inlier,
                                            bit fin);
    depth_point_t p;
    p.x        = CW'(x);
    p.y        = CW'(y);
    p.z        = CW'(z);
    p.valid    = ok;
    p.on_plane = inlier;
    p.last     = fin;
    return p;
  endfunction

  // Wide frames cover every coordinate bit; narrow ones sit near a typical
  // plane and draw z from a coarse grid so ties on z show up often.
  function automatic depth_point_t rand_point(bit wide, bit fin);
    if (wide)
      return mk_point($urandom, $urandom, $urandom, $urandom_range(0, 9) != 0,
                      $urandom_range(0, 3) == 0, fin);
    return mk_point(int'($urandom_range(0, 4000)) - 2000,
                    int'($urandom_range(0, 4000)) - 2000,
                    100 * int'($urandom_range(0, 15)) - 800,
                    $urandom_range(0, 9) != 0, $urandom_range(0, 3) == 0, fin);
  endfunction

  task automatic send_frame(bit wide);
    int len;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    for (int i = 0; i < len; i++)
      send_point(rand_point(wide, i == len - 1));
  endtask

  // Phase 0 and 1 hit the register extremes; later phases pick at random between
  // a plausible floor plane and fully random register contents.
  task automatic program_plane(int ph);
    bit plausible;
    plausible = $urandom_range(0, 1);
    if (ph == 0) begin
      write_reg(poc_pkg::REG_NORMAL_X, -32768);
      write_reg(poc_pkg::REG_NORMAL_Y, -32768);
      write_reg(poc_pkg::REG_NORMAL_Z, -32768);
      write_reg(poc_pkg::REG_OFFSET,   -131072);
      write_reg(poc_pkg::REG_DIST_THR, 0);
    end else if (ph == 1) begin
      write_reg(poc_pkg::REG_NORMAL_X, 32767);
      write_reg(poc_pkg::REG_NORMAL_Y, 32767);
      write_reg(poc_pkg::REG_NORMAL_Z, 32767);
      write_reg(poc_pkg::REG_OFFSET,   131071);
      write_reg(poc_pkg::REG_DIST_THR, 65535);
    end else if (plausible) begin
      write_reg(poc_pkg::REG_NORMAL_X, int'($urandom_range(0, 8000)) - 4000);
      write_reg(poc_pkg::REG_NORMAL_Y, int'($urandom_range(0, 8000)) - 4000);
      write_reg(poc_pkg::REG_NORMAL_Z, int'($urandom_range(12000, 16384)));
      write_reg(poc_pkg::REG_OFFSET,   int'($urandom_range(0, 6000)) - 3000);
      write_reg(poc_pkg::REG_DIST_THR, $urandom_range(0, 3000));
    end else begin
      write_reg(poc_pkg::REG_NORMAL_X, $urandom);
      write_reg(poc_pkg::REG_NORMAL_Y, $urandom);
      write_reg(poc_pkg::REG_NORMAL_Z, $urandom);
      write_reg(poc_pkg::REG_OFFSET,   $urandom);
      write_reg(poc_pkg::REG_DIST_THR, $urandom);
    end
  endtask

  // Block idle: all results back, then let the pipe settle.
  task automatic wait_drain();
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int phase_start;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    items_sent        = 0;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = poc_pkg::REG_NORMAL_X;
    cfg_data          = '0;
    pt_if.valid       = 1'b0;
    pt_if.point_x     = '0;
    pt_if.point_y     = '0;
    pt_if.point_z     = '0;
    pt_if.point_valid = 1'b0;
    pt_if.on_plane    = 1'b0;
    pt_if.last_point  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed frames at reset config: distance is just z, threshold 100.
    // single-point frame: first outlier is taken even at the z sentinel
    send_point(mk_point(1, 2, 32767, 1'b1, 1'b0, 1'b1));
    // tie on z keeps the earlier point; invalid and inlier points are
    // skipped even with the smallest z; the last point itself wins
    send_point(mk_point(-32768, 32767, 500, 1'b1, 1'b0, 1'b0));
    send_point(mk_point(5, 6, 500, 1'b1, 1'b0, 1'b0));
    send_point(mk_point(7, 8, -32768, 1'b0, 1'b0, 1'b0));
    send_point(mk_point(7, 8, -32768, 1'b1, 1'b1, 1'b0));
    send_point(mk_point(32767, -32768, 50, 1'b1, 1'b0, 1'b0));
    send_point(mk_point(9, 9, -101, 1'b1, 1'b0, 1'b1));
    // distance equal to the threshold is not an outlier: nothing found
    send_point(mk_point(-1, -1, 100, 1'b1, 1'b0, 1'b0));
    send_point(mk_point(-1, -1, -100, 1'b1, 1'b0, 1'b0));
    send_point(mk_point(0, 0, 0, 1'b1, 1'b0, 1'b1));
    // most negative z kept, last point skipped as invalid inlier
    send_point(mk_point(32767, -1, -32768, 1'b1, 1'b0, 1'b0));
    send_point(mk_point(0, 0, -32768, 1'b0, 1'b1, 1'b1));
    @(negedge clk_i);
    pt_if.valid = 1'b0;
    wait_drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      program_plane(ph);
      // pile up closed frames behind a stalled result port
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      phase_start = items_sent;
      while (items_sent - phase_start < ITEMS_PER_PHASE)
        send_frame($urandom_range(0, 1));
      @(negedge clk_i);
      pt_if.valid = 1'b0;
      wait_drain();
    end

    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
